>>> sv/msbx_pkg.sv
package msbx_pkg;

  localparam int NumShares = 3;
  localparam int RingLen   = NumShares * NumShares;
  localparam int PoolBytes = 42;
  localparam int Latency   = 6;

  localparam logic [7:0] AffineConst = 8'h63;
  localparam logic [8:0] AesPoly     = 9'h11b;

  typedef struct packed {
    logic [7:0]  share_in_0;
    logic [7:0]  share_in_1;
    logic [7:0]  share_in_2;
    logic [55:0] random_bytes_0;
    logic [55:0] random_bytes_1;
    logic [55:0] random_bytes_2;
    logic [55:0] random_bytes_3;
    logic [55:0] random_bytes_4;
    logic [55:0] random_bytes_5;
  } sbx_in_t;

  typedef struct packed {
    logic [7:0] share_out_0;
    logic [7:0] share_out_1;
    logic [7:0] share_out_2;
  } sbx_out_t;

  typedef logic [NumShares-1:0][7:0] shares_t;
  typedef logic [RingLen-1:0][7:0]   ring_t;
  typedef logic [NumShares-1:0][7:0] refresh_t;
  typedef logic [PoolBytes-1:0][7:0] pool_t;

  // Shift-and-add product in GF(2^8), reduced by the AES polynomial.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ AesPoly;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_sq(input logic [7:0] a);
    return gf_mul(a, a);
  endfunction

  function automatic logic [7:0] affine(input logic [7:0] x);
    logic [7:0] r1, r2, r3, r4;
    r1 = {x[6:0], x[7]};
    r2 = {x[5:0], x[7:6]};
    r3 = {x[4:0], x[7:5]};
    r4 = {x[3:0], x[7:4]};
    return x ^ r1 ^ r2 ^ r3 ^ r4 ^ AffineConst;
  endfunction

  // Squaring is linear, so it is applied to each share on its own.
  function automatic shares_t sq_shares(input shares_t s);
    shares_t res;
    for (int i = 0; i < NumShares; i++) begin
      res[i] = gf_sq(s[i]);
    end
    return res;
  endfunction

  // Pairs (0,1), (0,2), (1,2) each take one random byte.
  function automatic shares_t refresh(input shares_t s, input refresh_t r);
    shares_t res;
    res[0] = s[0] ^ r[0] ^ r[1];
    res[1] = s[1] ^ r[0] ^ r[2];
    res[2] = s[2] ^ r[1] ^ r[2];
    return res;
  endfunction

  // Each partial product a[i]*b[j] is masked by two neighboring bytes of the ring.
  function automatic shares_t masked_mul(input shares_t a, input shares_t b, input ring_t r);
    shares_t res;
    int      k;
    int      kn;
    for (int i = 0; i < NumShares; i++) begin
      res[i] = 8'h00;
      for (int j = 0; j < NumShares; j++) begin
        k      = i * NumShares + j;
        kn     = (k == RingLen - 1) ? 0 : k + 1;
        res[i] = res[i] ^ gf_mul(a[i], b[j]) ^ r[k] ^ r[kn];
      end
    end
    return res;
  endfunction

  // Unmasked S-box through the same addition chain for x^254.
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] x2, x3, x12, x15, x240, x252, x254;
    x2   = gf_sq(x);
    x3   = gf_mul(x2, x);
    x12  = gf_sq(gf_sq(x3));
    x15  = gf_mul(x12, x3);
    x240 = gf_sq(gf_sq(gf_sq(gf_sq(x15))));
    x252 = gf_mul(x240, x12);
    x254 = gf_mul(x252, x2);
    return affine(x254);
  endfunction

endpackage

>>> sv/masked_aes_sbox_three_share.sv
// Channel   Ports                         Transaction
// --------  ----------------------------  -------------------------------------
// input     start, busy, in_data          start high and busy low at the edge
// result    out_valid, out_data           out_valid high for one cycle
//
// Six register stages, one per masked product or refresh step; a new byte
// may enter in every cycle.
// busy is always low, so the block never refuses a transaction.
// Synchronous active-low reset clears the stage valid bits only.
// The receiver cannot stall, so results are never held back.
module masked_aes_sbox_three_share (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  msbx_pkg::sbx_in_t in_data,
  output logic              out_valid,
  output msbx_pkg::sbx_out_t out_data
);
  import msbx_pkg::*;

  logic [Latency-1:0] vld_r, vld_nxt;

  pool_t   pool_in;
  shares_t x_in;

  shares_t x_s1_r, z_s1_r, z_s1_nxt;
  pool_t   pool_s1_r;
  shares_t u_s2_r, u_s2_nxt, z_s2_r;
  pool_t   pool_s2_r;
  shares_t u_s3_r, w_s3_r, w_s3_nxt, z_s3_r;
  pool_t   pool_s3_r;
  shares_t v_s4_r, v_s4_nxt, w_s4_r, z_s4_r;
  pool_t   pool_s4_r;
  shares_t m_s5_r, m_s5_nxt, z_s5_r;
  pool_t   pool_s5_r;
  shares_t y_s6_r, y_s6_nxt;
  shares_t prod_s6;

  assign busy = 1'b0;

  assign pool_in = {in_data.random_bytes_5, in_data.random_bytes_4, in_data.random_bytes_3,
                    in_data.random_bytes_2, in_data.random_bytes_1, in_data.random_bytes_0};
  assign x_in    = {in_data.share_in_2, in_data.share_in_1, in_data.share_in_0};

  always_comb begin
    vld_nxt  = {vld_r[Latency-2:0], start && !busy};
    z_s1_nxt = refresh(sq_shares(x_in), pool_in[2:0]);
    u_s2_nxt = masked_mul(z_s1_r, x_s1_r, pool_s1_r[11:3]);
    w_s3_nxt = refresh(sq_shares(sq_shares(u_s2_r)), pool_s2_r[14:12]);
    v_s4_nxt = sq_shares(sq_shares(sq_shares(sq_shares(
                 masked_mul(u_s3_r, w_s3_r, pool_s3_r[23:15])))));
    m_s5_nxt = masked_mul(v_s4_r, w_s4_r, pool_s4_r[32:24]);
    prod_s6  = masked_mul(m_s5_r, z_s5_r, pool_s5_r[41:33]);
    for (int i = 0; i < NumShares; i++) begin
      y_s6_nxt[i] = affine(prod_s6[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_s1_r    <= x_in;
    z_s1_r    <= z_s1_nxt;
    pool_s1_r <= pool_in;

    u_s2_r    <= u_s2_nxt;
    z_s2_r    <= z_s1_r;
    pool_s2_r <= pool_s1_r;

    u_s3_r    <= u_s2_r;
    w_s3_r    <= w_s3_nxt;
    z_s3_r    <= z_s2_r;
    pool_s3_r <= pool_s2_r;

    v_s4_r    <= v_s4_nxt;
    w_s4_r    <= w_s3_r;
    z_s4_r    <= z_s3_r;
    pool_s4_r <= pool_s3_r;

    m_s5_r    <= m_s5_nxt;
    z_s5_r    <= z_s4_r;
    pool_s5_r <= pool_s4_r;

    y_s6_r    <= y_s6_nxt;
  end

  assign out_valid            = vld_r[Latency-1];
  assign out_data.share_out_0 = y_s6_r[0];
  assign out_data.share_out_1 = y_s6_r[1];
  assign out_data.share_out_2 = y_s6_r[2];

endmodule

>>> sv/msbx_checker.sv
module msbx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input msbx_pkg::sbx_in_t  in_data,
  input logic               out_valid,
  input msbx_pkg::sbx_out_t out_data
);
  import msbx_pkg::*;

  logic [7:0] in_xor;
  logic [7:0] out_xor;

  assign in_xor  = in_data.share_in_0 ^ in_data.share_in_1 ^ in_data.share_in_2;
  assign out_xor = out_data.share_out_0 ^ out_data.share_out_1 ^ out_data.share_out_2;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("accepted transaction did not produce a result after six cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result without a matching transaction");

  // The shares must recombine to the S-box of the recombined input.
  a_unmasked_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_xor == sbox($past(in_xor, 6))))
    else $error("recombined output is not the S-box of the recombined input");

endmodule

bind masked_aes_sbox_three_share msbx_checker u_msbx_checker (.*);

>>> sim/tb_masked_aes_sbox_three_share.sv
`timescale 1ns / 1ps

module tb_masked_aes_sbox_three_share;
  import msbx_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomCount  = 1600;
  localparam int MaxGap       = 6;
  localparam int ResetCycles  = 12;

  // Offsets into the random pool, in the order the masked chain uses them.
  localparam int RefreshSqBase  = 0;
  localparam int MulCubeBase    = 3;
  localparam int RefreshQuadBase = 12;
  localparam int MulFifteenBase = 15;
  localparam int Mul252Base     = 24;
  localparam int Mul254Base     = 33;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  sbx_in_t  in_data;
  logic     out_valid;
  sbx_out_t out_data;

  sbx_out_t sbox_expected[$];
  int       mismatches;
  int       cycles;
  logic     steady_flow;

  masked_aes_sbox_three_share dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] gf_square_n(input logic [7:0] a, input int n);
    logic [7:0] r;
    r = a;
    for (int i = 0; i < n; i++) begin
      r = gf_product(r, r);
    end
    return r;
  endfunction

  function automatic shares_t refresh_pairs(input shares_t s, input pool_t pool,
                                            input int base);
    shares_t res;
    res[0] = s[0] ^ pool[base] ^ pool[base + 1];
    res[1] = s[1] ^ pool[base] ^ pool[base + 2];
    res[2] = s[2] ^ pool[base + 1] ^ pool[base + 2];
    return res;
  endfunction

  // Every partial product a[i]*b[j] is masked by two neighboring ring bytes.
  function automatic shares_t masked_product(input shares_t a, input shares_t b,
                                             input pool_t pool, input int base);
    shares_t res;
    int      k;
    for (int i = 0; i < NumShares; i++) begin
      res[i] = 8'h00;
      for (int j = 0; j < NumShares; j++) begin
        k      = i * NumShares + j;
        res[i] = res[i] ^ gf_product(a[i], b[j]) ^ pool[base + k]
                 ^ pool[base + (k + 1) % RingLen];
      end
    end
    return res;
  endfunction

  function automatic sbx_out_t predict_sbox_shares(input sbx_in_t item);
    logic [5:0][55:0] fields;
    pool_t            pool;
    shares_t          x, z, u, w, v, m, y;
    logic [7:0]       b;
    sbx_out_t         res;
    fields = {item.random_bytes_5, item.random_bytes_4, item.random_bytes_3,
              item.random_bytes_2, item.random_bytes_1, item.random_bytes_0};
    for (int k = 0; k < PoolBytes; k++) begin
      pool[k] = fields[k / 7][8 * (k % 7) +: 8];
    end
    x[0] = item.share_in_0;
    x[1] = item.share_in_1;
    x[2] = item.share_in_2;
    for (int i = 0; i < NumShares; i++) begin
      z[i] = gf_square_n(x[i], 1);
    end
    z = refresh_pairs(z, pool, RefreshSqBase);
    u = masked_product(z, x, pool, MulCubeBase);
    for (int i = 0; i < NumShares; i++) begin
      w[i] = gf_square_n(u[i], 2);
    end
    w = refresh_pairs(w, pool, RefreshQuadBase);
    v = masked_product(u, w, pool, MulFifteenBase);
    for (int i = 0; i < NumShares; i++) begin
      v[i] = gf_square_n(v[i], 4);
    end
    m = masked_product(v, w, pool, Mul252Base);
    y = masked_product(m, z, pool, Mul254Base);
    // The affine map carries the constant into each of the three shares;
    // with an odd share count the constants still sum to one copy.
    for (int i = 0; i < NumShares; i++) begin
      b    = y[i];
      y[i] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
             ^ {b[3:0], b[7:4]} ^ AffineConst;
    end
    res.share_out_0 = y[0];
    res.share_out_1 = y[1];
    res.share_out_2 = y[2];
    return res;
  endfunction

  function automatic logic [55:0] random_field();
    logic [63:0] t;
    t = {$urandom(), $urandom()};
    return t[55:0];
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic sbx_in_t build_item(input logic [7:0] s0, input logic [7:0] s1,
                                         input logic [7:0] s2, input logic [55:0] f0,
                                         input logic [55:0] f1, input logic [55:0] f2,
                                         input logic [55:0] f3, input logic [55:0] f4,
                                         input logic [55:0] f5);
    sbx_in_t item;
    item.share_in_0     = s0;
    item.share_in_1     = s1;
    item.share_in_2     = s2;
    item.random_bytes_0 = f0;
    item.random_bytes_1 = f1;
    item.random_bytes_2 = f2;
    item.random_bytes_3 = f3;
    item.random_bytes_4 = f4;
    item.random_bytes_5 = f5;
    return item;
  endfunction

  // Start stays high from one transaction to the next when there is no gap.
  task automatic send_byte(input sbx_in_t item);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    sbox_expected.push_back(predict_sbox_shares(item));
  endtask

  // Unmasked inputs with an all-zero pool, including the zero byte whose
  // inverse is defined as zero.
  task automatic test_zero_pool();
    send_byte(build_item(8'h00, 8'h00, 8'h00, '0, '0, '0, '0, '0, '0));
    send_byte(build_item(8'hff, 8'h00, 8'h00, '0, '0, '0, '0, '0, '0));
    send_byte(build_item(8'h00, 8'hff, 8'h00, '0, '0, '0, '0, '0, '0));
    send_byte(build_item(8'h00, 8'h00, 8'hff, '0, '0, '0, '0, '0, '0));
    send_byte(build_item(8'hff, 8'hff, 8'hff, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_full_pool();
    send_byte(build_item(8'h00, 8'h00, 8'h00, '1, '1, '1, '1, '1, '1));
    send_byte(build_item(8'hff, 8'hff, 8'hff, '1, '1, '1, '1, '1, '1));
  endtask

  // One pool field at a time; the fields do not line up with the refresh and
  // product stages, so one field may feed two neighboring stages.
  task automatic test_pool_fields();
    logic [5:0][55:0] f;
    for (int n = 0; n < 6; n++) begin
      f    = '0;
      f[n] = '1;
      send_byte(build_item(random_byte(), random_byte(), random_byte(),
                           f[0], f[1], f[2], f[3], f[4], f[5]));
    end
  endtask

  task automatic test_masked_values();
    logic [7:0] plain [4];
    logic [7:0] a;
    logic [7:0] b;
    plain = '{8'h01, 8'h53, 8'hca, 8'h80};
    for (int n = 0; n < 4; n++) begin
      a = random_byte();
      b = random_byte();
      send_byte(build_item(a, b, plain[n] ^ a ^ b, random_field(), random_field(),
                           random_field(), random_field(), random_field(), random_field()));
    end
  endtask

  task automatic test_random_bytes();
    int      kind;
    sbx_in_t item;
    for (int n = 0; n < RandomCount; n++) begin
      if ($urandom_range(0, 63) == 0) begin
        steady_flow = !steady_flow;
      end
      kind = $urandom_range(0, 9);
      item = build_item(random_byte(), random_byte(), random_byte(),
                        random_field(), random_field(), random_field(),
                        random_field(), random_field(), random_field());
      if (kind == 0) begin
        item.random_bytes_0 = '0;
        item.random_bytes_1 = '0;
        item.random_bytes_2 = '0;
        item.random_bytes_3 = '0;
        item.random_bytes_4 = '0;
        item.random_bytes_5 = '0;
      end else if (kind == 1) begin
        item.random_bytes_0 = '1;
        item.random_bytes_1 = '1;
        item.random_bytes_2 = '1;
        item.random_bytes_3 = '1;
        item.random_bytes_4 = '1;
        item.random_bytes_5 = '1;
      end
      send_byte(item);
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    sbx_out_t want;
    if (rst_n && out_valid) begin
      if (sbox_expected.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        mismatches++;
      end else begin
        want = sbox_expected.pop_front();
        if (out_data.share_out_0 !== want.share_out_0) begin
          $error("share_out_0: expected %h, actual %h", want.share_out_0,
                 out_data.share_out_0);
          mismatches++;
        end
        if (out_data.share_out_1 !== want.share_out_1) begin
          $error("share_out_1: expected %h, actual %h", want.share_out_1,
                 out_data.share_out_1);
          mismatches++;
        end
        if (out_data.share_out_2 !== want.share_out_2) begin
          $error("share_out_2: expected %h, actual %h", want.share_out_2,
                 out_data.share_out_2);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    mismatches  = 0;
    cycles      = 0;
    steady_flow = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_pool();
    test_full_pool();
    test_pool_fields();
    test_masked_values();
    test_random_bytes();

    start <= 1'b0;
    while (sbox_expected.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
